// ===== rtl/core/e2q_pkg.sv =====
`default_nettype none

package e2q_pkg;

  // Field widths of the transactions.
  localparam int ANGLE_BITS     = 16;
  localparam int COMPONENT_BITS = 16;

  // Default number of CORDIC rotations, one pipeline stage each.
  localparam int CORDIC_STEPS_DEF = 16;

  // Internal datapath widths.
  localparam int XW = 32;  // CORDIC x and y, Q2.30
  localparam int ZW = 29;  // CORDIC angle accumulator, 2^-20 degree
  localparam int PW = 64;  // product of two terms, Q60
  localparam int RW = 33;  // product rounded back to Q30
  localparam int TW = 65;  // triple product, Q60
  localparam int SW = 66;  // sum of two triple products, Q60

  localparam int Q_FRAC    = 30;
  localparam int OUT_SHIFT = 60 - (COMPONENT_BITS - 1);

  // Half angle arithmetic in units of 1/128 degree.
  localparam logic [16:0] HALF_TURN_UNITS     = 17'd46080;
  localparam logic [16:0] QUARTER_UNITS       = 17'd11520;
  localparam logic [16:0] HALF_UNITS          = 17'd23040;
  localparam logic [16:0] THREE_QUARTER_UNITS = 17'd34560;
  localparam int          ANGLE_SCALE_SHIFT   = 13;

  localparam logic signed [XW-1:0] INV_GAIN_Q30 = 32'sd652032874;

  localparam int ATAN_DEG_Q20 [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469358,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;
  } quat_t;

  // Rotation angle of CORDIC step i, in accumulator units.
  function automatic logic signed [ZW-1:0] atan_z(input int i);
    logic [4:0] idx;
    idx = i[4:0];
    return ZW'(ATAN_DEG_Q20[idx]);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2q_cordic.sv =====
`default_nettype none

// Pipelined cosine and sine of a half angle: one range reduction stage,
// one stage per rotation and a final sign correction stage.
module e2q_cordic #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic signed [e2q_pkg::ANGLE_BITS-1:0]    angle_i,
  output logic signed [e2q_pkg::XW-1:0]                 cos_o,
  output logic signed [e2q_pkg::XW-1:0]                 sin_o
);

  logic signed [16:0]               a_ext;
  logic [16:0]                      a_pos;
  logic signed [16:0]               a_fold;
  logic                             fold_neg;

  logic signed [e2q_pkg::XW-1:0]    x_d   [CORDIC_STEPS+1];
  logic signed [e2q_pkg::XW-1:0]    y_d   [CORDIC_STEPS+1];
  logic signed [e2q_pkg::ZW-1:0]    z_d   [CORDIC_STEPS+1];
  logic                             neg_d [CORDIC_STEPS+1];
  logic signed [e2q_pkg::XW-1:0]    x_q   [CORDIC_STEPS+1];
  logic signed [e2q_pkg::XW-1:0]    y_q   [CORDIC_STEPS+1];
  logic signed [e2q_pkg::ZW-1:0]    z_q   [CORDIC_STEPS+1];
  logic                             neg_q [CORDIC_STEPS+1];

  logic signed [e2q_pkg::XW-1:0]    cos_q;
  logic signed [e2q_pkg::XW-1:0]    sin_q;

  // Reduce the half angle modulo a full turn and fold it into a quarter turn
  // either side of zero; a fold by a half turn flips both signs.
  always_comb begin
    a_ext = 17'(angle_i);
    if (a_ext[16]) begin
      a_pos = a_ext + e2q_pkg::HALF_TURN_UNITS;
    end else begin
      a_pos = a_ext;
    end
    fold_neg = 1'b0;
    if (a_pos > e2q_pkg::QUARTER_UNITS && a_pos < e2q_pkg::THREE_QUARTER_UNITS) begin
      a_fold   = a_pos - e2q_pkg::HALF_UNITS;
      fold_neg = 1'b1;
    end else if (a_pos >= e2q_pkg::THREE_QUARTER_UNITS) begin
      a_fold = a_pos - e2q_pkg::HALF_TURN_UNITS;
    end else begin
      a_fold = a_pos;
    end
  end

  always_comb begin
    x_d[0]   = e2q_pkg::INV_GAIN_Q30;
    y_d[0]   = '0;
    z_d[0]   = {a_fold[15:0], {e2q_pkg::ANGLE_SCALE_SHIFT{1'b0}}};
    neg_d[0] = fold_neg;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z_q[i][e2q_pkg::ZW-1]) begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - e2q_pkg::atan_z(i);
      end else begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + e2q_pkg::atan_z(i);
      end
      neg_d[i+1] = neg_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
    cos_q <= neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    sin_q <= neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

// ===== rtl/core/euler_to_quaternion_unit.sv =====
`default_nettype none

// Euler angles to orientation quaternion.
// A transaction is accepted at a rising clock edge where start is high and
// busy is low. busy is always low: the block is a fully pipelined datapath
// and takes a new set of angles in every clock cycle. angles_i carries pitch,
// yaw and roll in signed units of 1/64 degree; any code is legal.
// Each transaction produces exactly one result. done_o is high for exactly
// one cycle, and quat_o holds w, x, y and z in Q1.15 during that cycle.
// The receiver cannot hold results off, so nothing ever stalls; results
// leave in the order the angles arrived.
// The pipeline has one stage for range reduction, one per CORDIC rotation,
// one for the sign fix, then two-term product, rounding, triple product,
// sum and the output register.
// The sustained rate is one transaction per cycle; each CORDIC rotation and
// each multiplier rank owns a pipeline stage.
// Reset clears only the valid pipeline, so no result appears after reset
// until new angles are accepted; the data registers are not reset.
module euler_to_quaternion_unit #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire e2q_pkg::angles_t angles_i,
  output logic                  done_o,
  output e2q_pkg::quat_t        quat_o
);

  // Total pipeline depth in register stages.
  localparam int VLEN = CORDIC_STEPS + 7;

  // Indices of the two-term products.
  localparam int CC = 0;  // c1 c2
  localparam int SS = 1;  // s1 s2
  localparam int SC = 2;  // s1 c2
  localparam int CS = 3;  // c1 s2

  localparam int VW = e2q_pkg::SW - e2q_pkg::OUT_SHIFT;
  localparam int CB = e2q_pkg::COMPONENT_BITS;

  localparam logic signed [e2q_pkg::PW-1:0] RND_HALF =
    e2q_pkg::PW'(1) << (e2q_pkg::Q_FRAC - 1);
  localparam logic signed [e2q_pkg::SW-1:0] OUT_HALF =
    e2q_pkg::SW'(1) << (e2q_pkg::OUT_SHIFT - 1);
  localparam logic signed [VW-1:0] SAT_HI = VW'((1 <<< (CB - 1)) - 1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  logic                               accept;
  logic [VLEN-1:0]                    valid_q;

  // Lane 1 is yaw, lane 2 is pitch, lane 3 is roll.
  logic signed [e2q_pkg::XW-1:0]      c1, s1, c2, s2, c3, s3;
  logic signed [e2q_pkg::XW-1:0]      c3_p_q, s3_p_q, c3_r_q, s3_r_q;

  logic signed [e2q_pkg::PW-1:0]      prod_q [4];
  logic signed [e2q_pkg::RW-1:0]      rnd_d  [4];
  logic signed [e2q_pkg::RW-1:0]      rnd_q  [4];
  logic signed [e2q_pkg::TW-1:0]      tri_q  [8];
  logic signed [e2q_pkg::SW-1:0]      sum_q  [4];
  logic signed [e2q_pkg::SW-1:0]      sum_rnd [4];
  logic signed [VW-1:0]               comp_v [4];
  logic signed [CB-1:0]               comp_d [4];
  e2q_pkg::quat_t                     quat_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  e2q_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_yaw (
    .clk_i   (clk_i),
    .angle_i (angles_i.yaw_angle),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  e2q_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_pitch (
    .clk_i   (clk_i),
    .angle_i (angles_i.pitch_angle),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  e2q_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic_roll (
    .clk_i   (clk_i),
    .angle_i (angles_i.roll_angle),
    .cos_o   (c3),
    .sin_o   (s3)
  );

  // The valid bit of each transaction moves with its data, one stage a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[VLEN-2:0], accept};
    end
  end

  // Round each two-term product from Q60 back to Q30.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd_d[k] = e2q_pkg::RW'((prod_q[k] + RND_HALF) >>> e2q_pkg::Q_FRAC);
    end
  end

  // Round the sums to the output format and saturate.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_rnd[k] = (sum_q[k] + OUT_HALF) >>> e2q_pkg::OUT_SHIFT;
      comp_v[k]  = VW'(sum_rnd[k]);
      if (comp_v[k] > SAT_HI) begin
        comp_d[k] = CB'(SAT_HI);
      end else if (comp_v[k] < SAT_LO) begin
        comp_d[k] = CB'(SAT_LO);
      end else begin
        comp_d[k] = CB'(comp_v[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Two-term products of the yaw and pitch terms; roll waits alongside.
    prod_q[CC] <= c1 * c2;
    prod_q[SS] <= s1 * s2;
    prod_q[SC] <= s1 * c2;
    prod_q[CS] <= c1 * s2;
    c3_p_q     <= c3;
    s3_p_q     <= s3;

    rnd_q  <= rnd_d;
    c3_r_q <= c3_p_q;
    s3_r_q <= s3_p_q;

    // Triple products, paired per component.
    tri_q[0] <= rnd_q[CC] * c3_r_q;
    tri_q[1] <= rnd_q[SS] * s3_r_q;
    tri_q[2] <= rnd_q[SS] * c3_r_q;
    tri_q[3] <= rnd_q[CC] * s3_r_q;
    tri_q[4] <= rnd_q[SC] * c3_r_q;
    tri_q[5] <= rnd_q[CS] * s3_r_q;
    tri_q[6] <= rnd_q[CS] * c3_r_q;
    tri_q[7] <= rnd_q[SC] * s3_r_q;

    sum_q[0] <= e2q_pkg::SW'(tri_q[0]) - e2q_pkg::SW'(tri_q[1]);
    sum_q[1] <= e2q_pkg::SW'(tri_q[2]) + e2q_pkg::SW'(tri_q[3]);
    sum_q[2] <= e2q_pkg::SW'(tri_q[4]) + e2q_pkg::SW'(tri_q[5]);
    sum_q[3] <= e2q_pkg::SW'(tri_q[6]) - e2q_pkg::SW'(tri_q[7]);

    quat_q.quat_w <= comp_d[0];
    quat_q.quat_x <= comp_d[1];
    quat_q.quat_y <= comp_d[2];
    quat_q.quat_z <= comp_d[3];
  end

  assign done_o = valid_q[VLEN-1];
  assign quat_o = quat_q;

  // Every accepted transaction yields a result after the full pipeline depth.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##VLEN done_o)
    else $error("accepted transaction produced no result");

  // A cycle without a transaction yields no result.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##VLEN !done_o)
    else $error("result produced without a transaction");

  // Zero angles give the identity rotation, whose scalar part is positive.
  a_identity_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && angles_i == '0) |-> ##VLEN !quat_o.quat_w[CB-1])
    else $error("identity rotation produced a negative scalar part");

endmodule

`default_nettype wire

// ===== bench/euler_to_quaternion_unit_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the Euler angle to quaternion unit.
//
// An initial block fills a queue with angle sets. It starts with a short
// directed list: field extremes, the fold points of the half angle, the
// half-turn angles that drive a component to plus or minus one and into
// saturation, and alternating bit patterns. A random part follows.
// A driver at the falling edge presents the queue head with start and
// inserts random idle bursts. A monitor at the rising edge predicts every
// accepted transaction into a queue of expected quaternions and checks
// each done strobe against the oldest entry, one component at a time.
module euler_to_quaternion_unit_test;

  localparam int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF;
  localparam int PIPE_DEPTH   = CORDIC_STEPS + 7;
  localparam int RANDOM_ITEMS = 1025;
  localparam int QUIET_TAIL   = 150;     // last transactions are sent back to back
  localparam int CYCLE_LIMIT  = 200000;  // about ten times the slowest correct run
  localparam int PRINT_CAP    = 40;

  // Angle arithmetic constants, widened once for the 64-bit predictor.
  localparam longint HALF_TURN   = longint'(e2q_pkg::HALF_TURN_UNITS);
  localparam longint QUARTER     = longint'(e2q_pkg::QUARTER_UNITS);
  localparam longint HALF        = longint'(e2q_pkg::HALF_UNITS);
  localparam longint THREE_QUART = longint'(e2q_pkg::THREE_QUARTER_UNITS);
  localparam longint COMP_MAX    = (longint'(1) <<< (e2q_pkg::COMPONENT_BITS - 1)) - 1;
  localparam longint COMP_MIN    = -COMP_MAX - 1;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  e2q_pkg::angles_t angles = '0;
  logic             busy;
  logic             done;
  e2q_pkg::quat_t   quat;

  // Angle sets waiting to be sent; the head is what the driver presents.
  e2q_pkg::angles_t angle_queue[$];
  // Quaternions predicted for accepted transactions, oldest first.
  e2q_pkg::quat_t   quat_expected[$];

  logic accepted_q = 1'b0;  // head of angle_queue was taken at the last rising edge
  int   gap_left = 0;
  int   errors = 0;
  int   results_seen = 0;
  int   cycle_count = 0;

  euler_to_quaternion_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .angles_i(angles),
    .done_o  (done),
    .quat_o  (quat)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cosine and sine of the half angle, Q2.30. The input count equals the
  // half angle in 1/128 degree. It is reduced modulo a full turn and folded
  // into the right half plane; a fold by half a turn flips both signs.
  function automatic void half_angle_trig(
      input logic signed [e2q_pkg::ANGLE_BITS-1:0] angle,
      output longint cos_q30, output longint sin_q30);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flipped;
    a = longint'(angle) % HALF_TURN;
    flipped = 1'b0;
    if (a < 0) begin
      a += HALF_TURN;
    end
    if (a > QUARTER && a < THREE_QUART) begin
      a -= HALF;
      flipped = 1'b1;
    end else if (a >= THREE_QUART) begin
      a -= HALF_TURN;
    end
    // The rotation accumulator counts 2^-20 degree.
    z = a * 8192;
    x = longint'(e2q_pkg::INV_GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      // A zero residual angle rotates in the positive direction.
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(e2q_pkg::ATAN_DEG_Q20[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(e2q_pkg::ATAN_DEG_Q20[i]);
      end
    end
    cos_q30 = flipped ? -x : x;
    sin_q30 = flipped ? -y : y;
  endfunction

  // Add half an LSB, then shift arithmetically (floor).
  function automatic longint round_down_by(input longint v, input int shift);
    return (v + (longint'(1) <<< (shift - 1))) >>> shift;
  endfunction

  // Q60 product of three Q30 terms; the first pair is rounded back to Q30.
  function automatic longint triple_q60(input longint a, input longint b, input longint c);
    return round_down_by(a * b, e2q_pkg::Q_FRAC) * c;
  endfunction

  function automatic logic signed [e2q_pkg::COMPONENT_BITS-1:0] q60_to_component(
      input longint q60);
    longint v;
    v = round_down_by(q60, e2q_pkg::OUT_SHIFT);
    if (v > COMP_MAX) begin
      v = COMP_MAX;
    end
    if (v < COMP_MIN) begin
      v = COMP_MIN;
    end
    return v[e2q_pkg::COMPONENT_BITS-1:0];
  endfunction

  // Yaw gives the first factor pair, pitch the second and roll the third.
  function automatic e2q_pkg::quat_t predict_quat(input e2q_pkg::angles_t in);
    longint c1, s1, c2, s2, c3, s3;
    e2q_pkg::quat_t q;
    half_angle_trig(in.yaw_angle, c1, s1);
    half_angle_trig(in.pitch_angle, c2, s2);
    half_angle_trig(in.roll_angle, c3, s3);
    q.quat_w = q60_to_component(triple_q60(c1, c2, c3) - triple_q60(s1, s2, s3));
    q.quat_x = q60_to_component(triple_q60(s1, s2, c3) + triple_q60(c1, c2, s3));
    q.quat_y = q60_to_component(triple_q60(s1, c2, c3) + triple_q60(c1, s2, s3));
    q.quat_z = q60_to_component(triple_q60(c1, s2, c3) - triple_q60(s1, c2, s3));
    return q;
  endfunction

  // One printed line per mismatch, up to a cap, and every one is counted.
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  task automatic check_component(input string name,
                                 input logic signed [e2q_pkg::COMPONENT_BITS-1:0] got,
                                 input logic signed [e2q_pkg::COMPONENT_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d quat_%s = %0d, predicted %0d",
                                results_seen, name, got, want));
    end
  endtask

  function automatic void queue_angles(input int pitch, input int yaw, input int roll);
    e2q_pkg::angles_t a;
    a.pitch_angle = e2q_pkg::ANGLE_BITS'(pitch);
    a.yaw_angle   = e2q_pkg::ANGLE_BITS'(yaw);
    a.roll_angle  = e2q_pkg::ANGLE_BITS'(roll);
    angle_queue.push_back(a);
  endfunction

  // A random angle: mostly any code at all, otherwise close to zero, a fold point,
  // a half turn or a field extreme, or a whole number of degrees.
  function automatic int random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      return int'($urandom_range(0, 65535));
    end else if (pick <= 7) begin
      case ($urandom_range(0, 6))
        0: return 0 + int'($urandom_range(0, 8)) - 4;
        1: return 11520 + int'($urandom_range(0, 8)) - 4;
        2: return -11520 + int'($urandom_range(0, 8)) - 4;
        3: return 23040 + int'($urandom_range(0, 8)) - 4;
        4: return -23040 + int'($urandom_range(0, 8)) - 4;
        5: return 32767 - int'($urandom_range(0, 4));
        default: return -32768 + int'($urandom_range(0, 4));
      endcase
    end
    return 64 * (int'($urandom_range(0, 1023)) - 512);
  endfunction

  // Stimulus and end of run.
  initial begin
    // Zero angles: w is exactly one and saturates to the largest code.
    queue_angles(0, 0, 0);
    // Field extremes, together and one at a time.
    queue_angles(32767, 32767, 32767);
    queue_angles(-32768, -32768, -32768);
    queue_angles(32767, 0, 0);
    queue_angles(0, 32767, 0);
    queue_angles(0, 0, 32767);
    queue_angles(-32768, 0, 0);
    queue_angles(0, -32768, 0);
    queue_angles(0, 0, -32768);
    // Either side of the quarter-turn fold of the half angle.
    queue_angles(11520, 0, 0);
    queue_angles(11521, 0, 0);
    queue_angles(0, 11519, 0);
    queue_angles(0, -11520, 0);
    queue_angles(0, 0, -11521);
    // Half-turn half angles push single components to plus or minus one.
    queue_angles(23040, 0, 0);
    queue_angles(0, 23040, 0);
    queue_angles(0, 0, 23040);
    queue_angles(-23040, 0, 0);
    queue_angles(23040, 23040, 23040);
    queue_angles(5760, 5760, 5760);
    // Smallest steps around zero and alternating bit patterns.
    queue_angles(1, 1, 1);
    queue_angles(-1, -1, -1);
    queue_angles(16'h5555, 16'haaaa, 16'h5555);
    queue_angles(16'haaaa, 16'h5555, 16'haaaa);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_angles(random_angle(), random_angle(), random_angle());
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (angle_queue.size() != 0 || quat_expected.size() != 0) begin
      @(posedge clk_i);
    end
    // Wait out the pipeline so that any stray result would show up.
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: changes inputs on the falling edge. Once the head transaction
  // has been taken it is dropped, and now and then a random idle burst is
  // inserted before the next one. The tail of the run is sent
  // with no idling so the pipeline also sees a long unbroken stream.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (accepted_q) begin
        void'(angle_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (angle_queue.size() == 0) begin
        start <= 1'b0;
      end else if (accepted_q && angle_queue.size() > QUIET_TAIL &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 14);
        start <= 1'b0;
      end else begin
        start  <= 1'b1;
        angles <= angle_queue[0];
      end
    end
  end

  // Monitor: on each rising edge, a transaction taken by the block is
  // predicted, and a done strobe is checked against the oldest prediction.
  always @(posedge clk_i) begin
    e2q_pkg::quat_t want;
    accepted_q <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      quat_expected.push_back(predict_quat(angles));
    end
    if (rst_ni && done) begin
      if (quat_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = quat_expected.pop_front();
        check_component("w", quat.quat_w, want.quat_w);
        check_component("x", quat.quat_x, want.quat_x);
        check_component("y", quat.quat_y, want.quat_y);
        check_component("z", quat.quat_z, want.quat_z);
      end
      results_seen++;
    end
  end

  // Watchdog for a hung handshake or results that never come.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic.sv
rtl/core/euler_to_quaternion_unit.sv
bench/euler_to_quaternion_unit_test.sv
